/* hw/rtl/hrlt_pkg.sv */
// shared types, codes and constants for the http request line tokenizer
// no dependencies
`timescale 1ns / 1ps

package hrlt_pkg;

  localparam int BYTE_W   = 8;
  localparam int ROLE_W   = 3;
  localparam int VIDX_W   = 4;
  localparam int KIND_W   = 2;
  localparam int MIME_W   = 3;
  localparam int VCOUNT_W = 5;

  localparam int DEF_MAX_METHOD_LEN   = 10;
  localparam int DEF_MAX_RESOURCE_LEN = 1024;
  localparam int DEF_MAX_VALUES       = 10;
  localparam int DEF_MAX_VALUE_LEN    = 64;

  typedef enum logic [ROLE_W-1:0] {
    ROLE_IGNORED  = 3'd0,
    ROLE_METHOD   = 3'd1,
    ROLE_RESOURCE = 3'd2,
    ROLE_VALUE    = 3'd3,
    ROLE_SUMMARY  = 3'd4
  } role_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_EMPTY  = 2'd0,
    KIND_DOT    = 2'd1,
    KIND_NO_DOT = 2'd2
  } kind_t;

  typedef enum logic [MIME_W-1:0] {
    MIME_NONE = 3'd0,
    MIME_HTML = 3'd1,
    MIME_CSS  = 3'd2,
    MIME_JS   = 3'd3,
    MIME_PNG  = 3'd4,
    MIME_JPEG = 3'd5,
    MIME_BMP  = 3'd6,
    MIME_ICON = 3'd7
  } mime_t;

  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QUEST = 8'h3f;
  localparam logic [BYTE_W-1:0] CH_EQUAL = 8'h3d;
  localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [BYTE_W-1:0] CH_UP_A  = 8'd65;
  localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'd90;
  localparam logic [BYTE_W-1:0] CASE_OFS = 8'd32;

  // extension bytes packed first character in the low byte
  localparam logic [31:0] EXT_HTML = "lmth";
  localparam logic [31:0] EXT_JPEG = "gepj";
  localparam logic [31:0] EXT_CSS  = {8'h00, "ssc"};
  localparam logic [31:0] EXT_PNG  = {8'h00, "gnp"};
  localparam logic [31:0] EXT_JPG  = {8'h00, "gpj"};
  localparam logic [31:0] EXT_BMP  = {8'h00, "pmb"};
  localparam logic [31:0] EXT_ICO  = {8'h00, "oci"};
  localparam logic [31:0] EXT_JS   = {16'h0000, "sj"};

  function automatic mime_t mime_of_ext(logic [31:0] e, logic [2:0] n);
    mime_t m;
    m = MIME_NONE;
    case (n)
      3'd4: begin
        if (e == EXT_HTML) m = MIME_HTML;
        else if (e == EXT_JPEG) m = MIME_JPEG;
      end
      3'd3: begin
        if (e == EXT_CSS) m = MIME_CSS;
        else if (e == EXT_PNG) m = MIME_PNG;
        else if (e == EXT_JPG) m = MIME_JPEG;
        else if (e == EXT_BMP) m = MIME_BMP;
        else if (e == EXT_ICO) m = MIME_ICON;
      end
      3'd2: begin
        if (e == EXT_JS) m = MIME_JS;
      end
      default: m = MIME_NONE;
    endcase
    return m;
  endfunction

endpackage

/* hw/rtl/hrlt_if.sv */
// valid/ready channel interfaces for request bytes and tokenizer results
// depends on hrlt_pkg
`timescale 1ns / 1ps

interface hrlt_req_if
  import hrlt_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] request_byte;
  logic              end_of_request;

  modport source (output valid, output request_byte, output end_of_request, input ready);
  modport sink (input valid, input request_byte, input end_of_request, output ready);
endinterface

interface hrlt_res_if
  import hrlt_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   echo_byte;
  logic [ROLE_W-1:0]   byte_role;
  logic [VIDX_W-1:0]   value_index;
  logic [KIND_W-1:0]   resource_kind;
  logic [MIME_W-1:0]   mime_code;
  logic [VCOUNT_W-1:0] value_count;
  logic                overflow;

  modport source (
    output valid, output echo_byte, output byte_role, output value_index,
    output resource_kind, output mime_code, output value_count, output overflow,
    input ready
  );
  modport sink (
    input valid, input echo_byte, input byte_role, input value_index,
    input resource_kind, input mime_code, input value_count, input overflow,
    output ready
  );
endinterface

/* hw/rtl/http_request_line_tokenizer_top.sv */
// a request byte passes through the input register, then the result register
// one byte per cycle unless res stalls; only an empty input register fills while a result waits
// the per-byte parser state update sits between the two registers
// reset (rst, synchronous): both stages empty, parser back in the method phase, counts cleared
// the parser also returns to its reset state after a byte marked end_of_request
// depends on hrlt_pkg and hrlt_if
`timescale 1ns / 1ps

module http_request_line_tokenizer_top
  import hrlt_pkg::*;
#(
  parameter int MAX_METHOD_LEN   = DEF_MAX_METHOD_LEN,
  parameter int MAX_RESOURCE_LEN = DEF_MAX_RESOURCE_LEN,
  parameter int MAX_VALUES       = DEF_MAX_VALUES,
  parameter int MAX_VALUE_LEN    = DEF_MAX_VALUE_LEN
) (
  input  logic       clk,
  input  logic       rst,
  hrlt_req_if.sink   req,
  hrlt_res_if.source res
);

  localparam int MLW = $clog2(MAX_METHOD_LEN + 1);
  localparam int RLW = $clog2(MAX_RESOURCE_LEN + 1);
  localparam int VSW = $clog2(MAX_VALUES + 1);
  localparam int VLW = $clog2(MAX_VALUE_LEN + 1);

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_SLASH,
    PH_RESOURCE,
    PH_KEY,
    PH_VALUE,
    PH_DONE
  } phase_t;

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  // parser state
  phase_t         phase, phase_next;
  logic [MLW-1:0] method_length, method_length_next;
  logic [RLW-1:0] resource_length, resource_length_next;
  logic           dot_seen, dot_seen_next;
  logic           dot_at_start, dot_at_start_next;
  logic [31:0]    extension_chars, extension_chars_next;
  logic [2:0]     extension_length, extension_length_next;
  logic [VSW-1:0] values_seen, values_seen_next;
  logic [VLW-1:0] value_length, value_length_next;
  logic           overflow_seen, overflow_seen_next;

  // result register
  logic                res_valid;
  logic [BYTE_W-1:0]   echo_byte;
  role_t               byte_role, byte_role_next;
  logic [VIDX_W-1:0]   value_index, value_index_next;
  kind_t               resource_kind, resource_kind_next;
  mime_t               mime_code, mime_code_next;
  logic [VCOUNT_W-1:0] value_count, value_count_next;
  logic                overflow;

  logic              advance;
  logic              move;
  logic              line_end;
  logic [BYTE_W-1:0] lower_byte;

  assign advance   = !res_valid || res.ready;
  assign move      = in_valid && advance;
  assign req.ready = !in_valid || advance;

  assign lower_byte = (in_byte >= CH_UP_A && in_byte <= CH_UP_Z) ? in_byte + CASE_OFS : in_byte;

  always_comb begin
    phase_next            = phase;
    method_length_next    = method_length;
    resource_length_next  = resource_length;
    dot_seen_next         = dot_seen;
    dot_at_start_next     = dot_at_start;
    extension_chars_next  = extension_chars;
    extension_length_next = extension_length;
    values_seen_next      = values_seen;
    value_length_next     = value_length;
    overflow_seen_next    = overflow_seen;
    byte_role_next        = ROLE_IGNORED;
    value_index_next      = '0;
    resource_kind_next    = KIND_EMPTY;
    mime_code_next        = MIME_NONE;
    value_count_next      = '0;
    line_end              = 1'b0;

    case (phase)
      PH_METHOD: begin
        if (in_byte == CH_SPACE) begin
          phase_next = PH_SLASH;
        end else if (method_length < MLW'(MAX_METHOD_LEN)) begin
          method_length_next = method_length + 1'b1;
          byte_role_next     = ROLE_METHOD;
        end else begin
          overflow_seen_next = 1'b1;
        end
      end
      PH_SLASH: begin
        phase_next = PH_RESOURCE;
      end
      PH_RESOURCE: begin
        if (in_byte == CH_SPACE) begin
          line_end = 1'b1;
        end else if (in_byte == CH_QUEST) begin
          phase_next = PH_KEY;
        end else if (resource_length < RLW'(MAX_RESOURCE_LEN)) begin
          if (in_byte == CH_DOT) begin
            dot_seen_next         = 1'b1;
            dot_at_start_next     = (resource_length == '0);
            extension_chars_next  = '0;
            extension_length_next = '0;
          end else begin
            for (int k = 0; k < 4; k++) begin
              if (extension_length == 3'(k)) begin
                extension_chars_next[8*k +: 8] = extension_chars[8*k +: 8] | lower_byte;
              end
            end
            if (extension_length < 3'd5) begin
              extension_length_next = extension_length + 3'd1;
            end
          end
          resource_length_next = resource_length + 1'b1;
          byte_role_next       = ROLE_RESOURCE;
        end else begin
          overflow_seen_next = 1'b1;
        end
      end
      PH_KEY: begin
        if (in_byte == CH_SPACE) begin
          line_end = 1'b1;
        end else if (in_byte == CH_EQUAL) begin
          phase_next = PH_VALUE;
          if (values_seen < VSW'(MAX_VALUES)) begin
            values_seen_next  = values_seen + 1'b1;
            value_length_next = '0;
          end else begin
            overflow_seen_next = 1'b1;
            value_length_next  = VLW'(MAX_VALUE_LEN);
          end
        end
      end
      PH_VALUE: begin
        if (in_byte == CH_SPACE) begin
          line_end = 1'b1;
        end else if (in_byte == CH_AMP) begin
          phase_next = PH_KEY;
        end else if (value_length < VLW'(MAX_VALUE_LEN)) begin
          value_length_next = value_length + 1'b1;
          byte_role_next    = ROLE_VALUE;
          value_index_next  = VIDX_W'(values_seen - 1'b1);
        end else begin
          overflow_seen_next = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (line_end) begin
      phase_next       = PH_DONE;
      byte_role_next   = ROLE_SUMMARY;
      value_count_next = VCOUNT_W'(values_seen);
      if (resource_length != '0) begin
        resource_kind_next = dot_seen ? KIND_DOT : KIND_NO_DOT;
        if (resource_length >= RLW'(4) && dot_seen && !dot_at_start) begin
          mime_code_next = mime_of_ext(extension_chars, extension_length);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      in_byte <= req.request_byte;
      in_last <= req.end_of_request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_METHOD;
      method_length    <= '0;
      resource_length  <= '0;
      dot_seen         <= 1'b0;
      dot_at_start     <= 1'b0;
      extension_chars  <= '0;
      extension_length <= '0;
      values_seen      <= '0;
      value_length     <= '0;
      overflow_seen    <= 1'b0;
    end else if (move) begin
      if (in_last) begin
        phase            <= PH_METHOD;
        method_length    <= '0;
        resource_length  <= '0;
        dot_seen         <= 1'b0;
        dot_at_start     <= 1'b0;
        extension_chars  <= '0;
        extension_length <= '0;
        values_seen      <= '0;
        value_length     <= '0;
        overflow_seen    <= 1'b0;
      end else begin
        phase            <= phase_next;
        method_length    <= method_length_next;
        resource_length  <= resource_length_next;
        dot_seen         <= dot_seen_next;
        dot_at_start     <= dot_at_start_next;
        extension_chars  <= extension_chars_next;
        extension_length <= extension_length_next;
        values_seen      <= values_seen_next;
        value_length     <= value_length_next;
        overflow_seen    <= overflow_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= in_valid;
    end
    if (move) begin
      echo_byte     <= in_byte;
      byte_role     <= byte_role_next;
      value_index   <= value_index_next;
      resource_kind <= resource_kind_next;
      mime_code     <= mime_code_next;
      value_count   <= value_count_next;
      overflow      <= overflow_seen_next;
    end
  end

  assign res.valid         = res_valid;
  assign res.echo_byte     = echo_byte;
  assign res.byte_role     = byte_role;
  assign res.value_index   = value_index;
  assign res.resource_kind = resource_kind;
  assign res.mime_code     = mime_code;
  assign res.value_count   = value_count;
  assign res.overflow      = overflow;

  // summary fields only on the line end result
  assert property (@(posedge clk) disable iff (rst)
    res_valid && byte_role != ROLE_SUMMARY |->
      resource_kind == KIND_EMPTY && mime_code == MIME_NONE && value_count == '0)
    else $error("summary fields set on a non summary result");

  // a recognized type needs a resource with a dot
  assert property (@(posedge clk) disable iff (rst)
    res_valid && mime_code != MIME_NONE |-> resource_kind == KIND_DOT)
    else $error("mime code without a dotted resource");

  assert property (@(posedge clk) disable iff (rst)
    values_seen <= VSW'(MAX_VALUES) && method_length <= MLW'(MAX_METHOD_LEN))
    else $error("counter past its bound");

  // a byte marked last leaves the parser in the method phase
  assert property (@(posedge clk) disable iff (rst)
    move && in_last |=> phase == PH_METHOD && values_seen == '0 && !overflow_seen)
    else $error("state not cleared after end of request");

  // a stalled result is not overwritten
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.ready |=> res_valid && $stable(echo_byte) && $stable(byte_role))
    else $error("stalled result lost");

endmodule
